FILE: sv/trs_pkg.sv
// Package with the pipeline payload types and the single-precision arithmetic helpers.
`timescale 1ns / 1ps
package trs_pkg;

  typedef logic [31:0] fp32_t;

  localparam fp32_t FpZero     = 32'h0000_0000;
  localparam fp32_t FpOne      = 32'h3F80_0000;
  localparam fp32_t FpTwo      = 32'h4000_0000;
  localparam fp32_t FpCanonNan = 32'h7FC0_0000;
  localparam logic [7:0] ExpAllOnes = 8'hFF;

  // Products of the quaternion plus cleaned scale and translation.
  typedef struct packed {
    fp32_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
    fp32_t s2x, s2y, s2z;
    fp32_t sx, sy, sz;
    fp32_t tx, ty, tz;
  } trs_prod_t;

  // Brackets and diagonal terms on their way to the final scaling.
  typedef struct packed {
    fp32_t b01, b02, b10, b12, b20, b21;
    fp32_t d0, d1, d2;
    fp32_t s2x, s2y, s2z;
    fp32_t sx, sy, sz;
    fp32_t tx, ty, tz;
  } trs_mid_t;

  // Stage control shared by all pipeline modules.
  typedef struct packed {
    logic en;
  } trs_ctrl_t;

  function automatic logic fp_finite(fp32_t a);
    return a[30:23] != ExpAllOnes;
  endfunction

  function automatic fp32_t fp_canon(fp32_t a);
    if (a[30:23] == ExpAllOnes && a[22:0] != 23'd0) return FpCanonNan;
    return a;
  endfunction

  // Normalize, round to nearest even and pack. Value is mant * 2^(exp_in - 127 - 47).
  function automatic fp32_t fp_round_pack(logic sign, logic signed [11:0] exp_in,
                                          logic [47:0] mant);
    logic [5:0]         lz;
    logic               found;
    logic [47:0]        m;
    logic signed [11:0] e;
    logic [11:0]        sh;
    logic               sticky;
    logic               inc;
    logic [24:0]        r;
    logic [22:0]        frac;
    logic [7:0]         fexp;
    lz = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && mant[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    m = mant << lz;
    e = exp_in - $signed({6'b0, lz});
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh >= 12'd48) begin
        sticky = |m;
        m = 48'd0;
      end else begin
        sticky = |(m & ((48'd1 << sh) - 48'd1));
        m = m >> sh;
      end
      m[0] = m[0] | sticky;
      e = 12'sd1;
    end
    inc = m[23] & ((|m[22:0]) | m[24]);
    r = {1'b0, m[47:24]} + {24'd0, inc};
    if (r[24]) begin
      e = e + 12'sd1;
      frac = r[23:1];
      fexp = 8'(e);
    end else begin
      frac = r[22:0];
      fexp = r[23] ? 8'(e) : 8'd0;
    end
    if (mant == 48'd0) return {sign, 31'd0};
    if (e >= 12'sd255) return {sign, ExpAllOnes, 23'd0};
    return {sign, fexp, frac};
  endfunction

  function automatic fp32_t fp_mul(fp32_t a, fp32_t b);
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, s;
    logic [23:0]        ma, mb;
    logic [7:0]         ea, eb;
    logic [47:0]        p;
    logic signed [11:0] e;
    nan_a  = a[30:23] == ExpAllOnes && a[22:0] != 23'd0;
    nan_b  = b[30:23] == ExpAllOnes && b[22:0] != 23'd0;
    inf_a  = a[30:23] == ExpAllOnes && a[22:0] == 23'd0;
    inf_b  = b[30:23] == ExpAllOnes && b[22:0] == 23'd0;
    zero_a = a[30:0] == 31'd0;
    zero_b = b[30:0] == 31'd0;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = {24'd0, ma} * {24'd0, mb};
    e  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) return FpCanonNan;
    if (inf_a || inf_b) return {s, ExpAllOnes, 23'd0};
    return fp_round_pack(s, e, p);
  endfunction

  function automatic fp32_t fp_add(fp32_t a, fp32_t b);
    logic        nan_a, nan_b, inf_a, inf_b, sticky;
    fp32_t       lg, sm;
    logic [7:0]  el, es, d;
    logic [47:0] am, bm, sum;
    nan_a = a[30:23] == ExpAllOnes && a[22:0] != 23'd0;
    nan_b = b[30:23] == ExpAllOnes && b[22:0] != 23'd0;
    inf_a = a[30:23] == ExpAllOnes && a[22:0] == 23'd0;
    inf_b = b[30:23] == ExpAllOnes && b[22:0] == 23'd0;
    if (a[30:0] < b[30:0]) begin
      lg = b;
      sm = a;
    end else begin
      lg = a;
      sm = b;
    end
    el = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d  = el - es;
    am = {1'b0, lg[30:23] != 8'd0, lg[22:0], 23'd0};
    bm = {1'b0, sm[30:23] != 8'd0, sm[22:0], 23'd0};
    if (d >= 8'd48) begin
      sticky = |bm;
      bm = 48'd0;
    end else begin
      sticky = |(bm & ((48'd1 << d) - 48'd1));
      bm = bm >> d;
    end
    bm[0] = bm[0] | sticky;
    sum = (lg[31] == sm[31]) ? am + bm : am - bm;
    if (nan_a || nan_b || (inf_a && inf_b && a[31] != b[31])) return FpCanonNan;
    if (inf_a) return a;
    if (inf_b) return b;
    if (sum == 48'd0) return {a[31] & b[31], 31'd0};
    return fp_round_pack(lg[31], $signed({4'b0, el}) + 12'sd1, sum);
  endfunction

  function automatic fp32_t fp_sub(fp32_t a, fp32_t b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

endpackage

FILE: sv/trs_quat_prod.sv
// First stage: input cleaning, quaternion products and doubled scales.
`timescale 1ns / 1ps
module trs_quat_prod (
  input  logic              clk_i,
  input  trs_pkg::trs_ctrl_t ctrl_i,
  input  trs_pkg::fp32_t    trans_x_i,
  input  trs_pkg::fp32_t    trans_y_i,
  input  trs_pkg::fp32_t    trans_z_i,
  input  trs_pkg::fp32_t    quat_x_i,
  input  trs_pkg::fp32_t    quat_y_i,
  input  trs_pkg::fp32_t    quat_z_i,
  input  trs_pkg::fp32_t    quat_w_i,
  input  trs_pkg::fp32_t    scale_x_i,
  input  trs_pkg::fp32_t    scale_y_i,
  input  trs_pkg::fp32_t    scale_z_i,
  output trs_pkg::trs_prod_t prod_o
);
  import trs_pkg::*;

  fp32_t     qx, qy, qz, qw, sx, sy, sz;
  logic      quat_ok;
  trs_prod_t prod_d, prod_q;

  always_comb begin
    quat_ok = fp_finite(quat_x_i) && fp_finite(quat_y_i) &&
              fp_finite(quat_z_i) && fp_finite(quat_w_i);
    qx = quat_ok ? quat_x_i : FpZero;
    qy = quat_ok ? quat_y_i : FpZero;
    qz = quat_ok ? quat_z_i : FpZero;
    qw = quat_ok ? quat_w_i : FpOne;
    sx = fp_finite(scale_x_i) ? scale_x_i : FpOne;
    sy = fp_finite(scale_y_i) ? scale_y_i : FpOne;
    sz = fp_finite(scale_z_i) ? scale_z_i : FpOne;
    prod_d.xx  = fp_mul(qx, qx);
    prod_d.yy  = fp_mul(qy, qy);
    prod_d.zz  = fp_mul(qz, qz);
    prod_d.xy  = fp_mul(qx, qy);
    prod_d.xz  = fp_mul(qx, qz);
    prod_d.yz  = fp_mul(qy, qz);
    prod_d.wx  = fp_mul(qw, qx);
    prod_d.wy  = fp_mul(qw, qy);
    prod_d.wz  = fp_mul(qw, qz);
    prod_d.s2x = fp_mul(sx, FpTwo);
    prod_d.s2y = fp_mul(sy, FpTwo);
    prod_d.s2z = fp_mul(sz, FpTwo);
    prod_d.sx  = sx;
    prod_d.sy  = sy;
    prod_d.sz  = sz;
    prod_d.tx  = fp_finite(trans_x_i) ? trans_x_i : FpZero;
    prod_d.ty  = fp_finite(trans_y_i) ? trans_y_i : FpZero;
    prod_d.tz  = fp_finite(trans_z_i) ? trans_z_i : FpZero;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: sv/trs_sum.sv
// Stages two to four: brackets and sums, doubling, and one minus the doubled sum.
`timescale 1ns / 1ps
module trs_sum (
  input  logic               clk_i,
  input  trs_pkg::trs_ctrl_t ctrl_i,
  input  trs_pkg::trs_prod_t prod_i,
  output trs_pkg::trs_mid_t  mid_o
);
  import trs_pkg::*;

  trs_mid_t s2_d, s2_q, s3_d, s3_q, s4_d, s4_q;

  always_comb begin
    s2_d.b01 = fp_sub(prod_i.xy, prod_i.wz);
    s2_d.b02 = fp_add(prod_i.xz, prod_i.wy);
    s2_d.b10 = fp_add(prod_i.xy, prod_i.wz);
    s2_d.b12 = fp_sub(prod_i.yz, prod_i.wx);
    s2_d.b20 = fp_sub(prod_i.xz, prod_i.wy);
    s2_d.b21 = fp_add(prod_i.yz, prod_i.wx);
    s2_d.d0  = fp_add(prod_i.yy, prod_i.zz);
    s2_d.d1  = fp_add(prod_i.xx, prod_i.zz);
    s2_d.d2  = fp_add(prod_i.xx, prod_i.yy);
    s2_d.s2x = prod_i.s2x;
    s2_d.s2y = prod_i.s2y;
    s2_d.s2z = prod_i.s2z;
    s2_d.sx  = prod_i.sx;
    s2_d.sy  = prod_i.sy;
    s2_d.sz  = prod_i.sz;
    s2_d.tx  = prod_i.tx;
    s2_d.ty  = prod_i.ty;
    s2_d.tz  = prod_i.tz;
  end

  always_comb begin
    s3_d    = s2_q;
    s3_d.d0 = fp_mul(FpTwo, s2_q.d0);
    s3_d.d1 = fp_mul(FpTwo, s2_q.d1);
    s3_d.d2 = fp_mul(FpTwo, s2_q.d2);
  end

  always_comb begin
    s4_d    = s3_q;
    s4_d.d0 = fp_sub(FpOne, s3_q.d0);
    s4_d.d1 = fp_sub(FpOne, s3_q.d1);
    s4_d.d2 = fp_sub(FpOne, s3_q.d2);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign mid_o = s4_q;

endmodule

FILE: sv/trs_scale.sv
// Final stage: column scaling of the rotation terms into the output register.
`timescale 1ns / 1ps
module trs_scale (
  input  logic               clk_i,
  input  trs_pkg::trs_ctrl_t ctrl_i,
  input  trs_pkg::trs_mid_t  mid_i,
  output trs_pkg::fp32_t     m_o [12]
);
  import trs_pkg::*;

  fp32_t m_d [12];
  fp32_t m_q [12];

  always_comb begin
    m_d[0]  = fp_canon(fp_mul(mid_i.sx, mid_i.d0));
    m_d[1]  = fp_canon(fp_mul(mid_i.s2y, mid_i.b01));
    m_d[2]  = fp_canon(fp_mul(mid_i.s2z, mid_i.b02));
    m_d[3]  = fp_canon(fp_mul(mid_i.s2x, mid_i.b10));
    m_d[4]  = fp_canon(fp_mul(mid_i.sy, mid_i.d1));
    m_d[5]  = fp_canon(fp_mul(mid_i.s2z, mid_i.b12));
    m_d[6]  = fp_canon(fp_mul(mid_i.s2x, mid_i.b20));
    m_d[7]  = fp_canon(fp_mul(mid_i.s2y, mid_i.b21));
    m_d[8]  = fp_canon(fp_mul(mid_i.sz, mid_i.d2));
    m_d[9]  = mid_i.tx;
    m_d[10] = mid_i.ty;
    m_d[11] = mid_i.tz;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) m_q <= m_d;
  end

  assign m_o = m_q;

endmodule

FILE: sv/trs_transform_to_matrix_core.sv
// Top level of the translation, rotation and scale to affine matrix pipeline.
// An accepted beat passes the product, bracket, doubling, subtraction and scaling registers in order.
// Throughput: one beat per cycle; five register stages, each holding about one
// single-precision multiply or add, advance together whenever the output can move.
// Reset clears only the stage valid bits; payload registers are not reset.
// The output stage register doubles as the output buffer of the pipeline.
`timescale 1ns / 1ps
module trs_transform_to_matrix_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         trans_x_i,
  input  logic [31:0]         trans_y_i,
  input  logic [31:0]         trans_z_i,
  input  logic [31:0]         quat_x_i,
  input  logic [31:0]         quat_y_i,
  input  logic [31:0]         quat_z_i,
  input  logic [31:0]         quat_w_i,
  input  logic [31:0]         scale_x_i,
  input  logic [31:0]         scale_y_i,
  input  logic [31:0]         scale_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         m00_o,
  output logic [31:0]         m01_o,
  output logic [31:0]         m02_o,
  output logic [31:0]         m10_o,
  output logic [31:0]         m11_o,
  output logic [31:0]         m12_o,
  output logic [31:0]         m20_o,
  output logic [31:0]         m21_o,
  output logic [31:0]         m22_o,
  output logic [31:0]         m03_o,
  output logic [31:0]         m13_o,
  output logic [31:0]         m23_o
);
  import trs_pkg::*;

  localparam int unsigned NumStages = 5;

  // One valid bit per stage; the last one marks the output register.
  logic [NumStages-1:0] valid_d, valid_q;
  trs_ctrl_t            ctrl;
  trs_prod_t            prod;
  trs_mid_t             mid;
  fp32_t                m [12];

  // The whole pipeline moves as one when the output register is empty or
  // its beat is being taken. Bubbles travel along as cleared valid bits.
  assign ctrl.en    = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o = ctrl.en;

  assign valid_d = {valid_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl.en) begin
      valid_q <= valid_d;
    end
  end

  // Stage one: cleaning of non-finite inputs and the nine quaternion products.
  trs_quat_prod u_prod (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .trans_x_i (trans_x_i),
    .trans_y_i (trans_y_i),
    .trans_z_i (trans_z_i),
    .quat_x_i  (quat_x_i),
    .quat_y_i  (quat_y_i),
    .quat_z_i  (quat_z_i),
    .quat_w_i  (quat_w_i),
    .scale_x_i (scale_x_i),
    .scale_y_i (scale_y_i),
    .scale_z_i (scale_z_i),
    .prod_o    (prod)
  );

  // Stages two to four: brackets, diagonal sums, doubling and subtraction from one.
  trs_sum u_sum (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .prod_i (prod),
    .mid_o  (mid)
  );

  // Stage five: per-column scaling and NaN canonicalization.
  trs_scale u_scale (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .mid_i  (mid),
    .m_o    (m)
  );

  assign out_valid_o = valid_q[NumStages-1];
  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];
  assign m03_o = m[9];
  assign m13_o = m[10];
  assign m23_o = m[11];

  // The translation column is always finite after cleaning.
  a_trans_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m03_o[30:23] != ExpAllOnes) && (m13_o[30:23] != ExpAllOnes) &&
                    (m23_o[30:23] != ExpAllOnes))
    else $error("translation column holds a non-finite value");

  // A NaN in m00, the first diagonal entry, is the canonical quiet NaN.
  a_diag_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && m00_o[30:23] == ExpAllOnes && m00_o[22:0] != 23'd0 |->
    m00_o == FpCanonNan)
    else $error("non-canonical NaN on m00");

  // An input beat taken into an empty pipeline that does not stall while it travels reaches the output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && valid_q == '0 ##1 in_ready_o ##1 in_ready_o ##1 in_ready_o
    ##1 in_ready_o |-> ##1 out_valid_o)
    else $error("pipeline lost a beat");

  // Nothing reaches an empty output register while the stage right behind it is empty.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && valid_q[NumStages-2] == 1'b0 |=> !out_valid_o)
    else $error("output beat appeared from an empty stage");

endmodule
